### rtl/lss_pkg.sv
// Shared types, codes and helpers for the LED matrix scroll sequencer.
// Used by lss_step and led_matrix_scroll_sequencer_core; no dependencies.
`default_nettype none

package lss_pkg;

  localparam int SCREEN_COLUMNS_DEF = 32;
  localparam int SCREEN_ROWS_DEF    = 16;
  localparam int HIDDEN_COLUMNS_DEF = 8;
  localparam int PAUSE_LIMIT_DEF    = 100;
  localparam int FAST_THRESHOLD_DEF = 5;
  localparam int FRAME_COUNT_DEF    = 8;

  localparam int MAX_TEXT_COLUMNS = 1024;
  localparam int OFFSET_W         = 14;
  localparam int IN_DATA_W        = 8;
  localparam int OUT_DATA_W       = 32;
  localparam int CFG_DATA_W       = 11;
  localparam int CFG_INDEX_W      = 2;

  localparam logic signed [15:0] OFF_MIN = -16'sd8192;
  localparam logic signed [15:0] OFF_MAX = 16'sd8191;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_PERIOD  = 2'd0,
    REG_SCROLL_MODE  = 2'd1,
    REG_TEXT_COLUMNS = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    MODE_LEFT       = 3'd0,
    MODE_RIGHT      = 3'd1,
    MODE_UP         = 3'd2,
    MODE_DOWN       = 3'd3,
    MODE_CONTINUOUS = 3'd4,
    MODE_TOP_SCROLL = 3'd5,
    MODE_UNUSED     = 3'd6
  } mode_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_SHIFT_IN = 2'd0,
    PH_HOLD     = 2'd1,
    PH_SHIFT_OUT = 2'd2,
    PH_ADVANCE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  step_period;
    logic [2:0]  scroll_mode;
    logic [10:0] text_columns;
  } cfg_t;

  typedef struct packed {
    logic [15:0]                rate_counter;
    logic signed [OFFSET_W-1:0] window_offset;
    logic [5:0]                 vertical_shift;
    logic                       shift_from_top;
    logic                       pausing;
    logic [7:0]                 pause_ticks;
    phase_t                     phase;
    logic [7:0]                 phase_ticks;
    logic [2:0]                 current_frame;
  } seq_state_t;

  function automatic logic signed [OFFSET_W-1:0] sat_offset(input logic signed [15:0] v);
    logic signed [OFFSET_W-1:0] r;
    if (v < OFF_MIN) r = OFF_MIN[OFFSET_W-1:0];
    else if (v > OFF_MAX) r = OFF_MAX[OFFSET_W-1:0];
    else r = v[OFFSET_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lss_step.sv
// Next-state logic for one transaction of the scroll sequencer: tick counting,
// scroll steps per mode and frame start. Depends on lss_pkg.
`default_nettype none

module lss_step #(
  parameter int SCREEN_COLUMNS = lss_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = lss_pkg::SCREEN_ROWS_DEF,
  parameter int HIDDEN_COLUMNS = lss_pkg::HIDDEN_COLUMNS_DEF,
  parameter int PAUSE_LIMIT    = lss_pkg::PAUSE_LIMIT_DEF,
  parameter int FAST_THRESHOLD = lss_pkg::FAST_THRESHOLD_DEF,
  parameter int FRAME_COUNT    = lss_pkg::FRAME_COUNT_DEF
) (
  input  lss_pkg::cfg_t       cfg,
  input  lss_pkg::seq_state_t cur,
  input  logic                operation,
  input  logic [2:0]          start_frame,
  output lss_pkg::seq_state_t nxt,
  output logic                frame_request
);
  import lss_pkg::*;

  localparam logic signed [15:0] SCREEN_BYTES = 16'(4 * SCREEN_COLUMNS);
  localparam logic signed [15:0] LIMIT_BASE   = 16'(4 * (SCREEN_COLUMNS + HIDDEN_COLUMNS));
  localparam logic [5:0]         ROWS_SHIFT   = 6'(SCREEN_ROWS);

  mode_t             mode;
  logic [10:0]       cols;
  logic signed [15:0] inc;
  logic signed [15:0] limit;
  logic signed [15:0] off;
  logic              top_in;
  logic              zero_shift;
  logic              top_out;
  logic              req;
  logic [3:0]        nf;
  logic [7:0]        old_pt;
  seq_state_t        s;

  always_comb begin
    mode = (cfg.scroll_mode >= 3'(MODE_UNUSED)) ? MODE_UNUSED : mode_t'(cfg.scroll_mode);
    cols = (int'(cfg.text_columns) > MAX_TEXT_COLUMNS) ? 11'd0 : cfg.text_columns;
    inc = (int'(cfg.step_period) > FAST_THRESHOLD) ? 16'sd4 : 16'sd8;
    limit = LIMIT_BASE + 16'({cols, 2'b00});
    top_in = (mode == MODE_UP);
    zero_shift = (mode != MODE_UP);
    top_out = (mode == MODE_DOWN);
  end

  always_comb begin
    s = cur;
    req = 1'b0;
    off = 16'(cur.window_offset);
    nf = '0;
    old_pt = '0;
    if (operation == OP_START) begin
      s.current_frame = (int'(start_frame) >= FRAME_COUNT) ? 3'd0 : start_frame;
      if (mode != MODE_UNUSED) begin
        s.phase_ticks = '0;
        s.pausing = 1'b0;
        s.phase = PH_SHIFT_IN;
        s.vertical_shift = '0;
        case (mode)
          MODE_RIGHT: begin
            s.window_offset = sat_offset(16'({cols, 2'b00}));
          end
          MODE_UP, MODE_DOWN: begin
            s.shift_from_top = (mode == MODE_DOWN);
            s.vertical_shift = ROWS_SHIFT;
            s.window_offset = sat_offset(SCREEN_BYTES);
          end
          MODE_TOP_SCROLL: begin
            s.shift_from_top = 1'b1;
            s.vertical_shift = ROWS_SHIFT;
            s.window_offset = '0;
          end
          default: begin
            s.window_offset = '0;
          end
        endcase
      end
    end else begin
      if (s.rate_counter != 16'hFFFF) s.rate_counter = s.rate_counter + 16'd1;
      if (s.rate_counter > {8'd0, cfg.step_period}) begin
        s.rate_counter = '0;
        case (mode)
          MODE_LEFT, MODE_RIGHT: begin
            if (!s.pausing) begin
              s.window_offset = sat_offset((mode == MODE_LEFT) ? off + inc : off - inc);
            end
            off = 16'(s.window_offset);
            if (off == SCREEN_BYTES) s.pausing = 1'b1;
            if (s.pausing) begin
              old_pt = s.pause_ticks;
              if (s.pause_ticks != 8'hFF) s.pause_ticks = s.pause_ticks + 8'd1;
              if (int'(old_pt) > PAUSE_LIMIT) begin
                s.pausing = 1'b0;
                s.pause_ticks = '0;
              end
            end
            if (mode == MODE_LEFT) begin
              if (off > limit) req = 1'b1;
            end else if (!s.pausing && off < 16'sd0) begin
              s.phase_ticks = '0;
              req = 1'b1;
            end
          end
          MODE_UP, MODE_DOWN, MODE_TOP_SCROLL: begin
            case (s.phase)
              PH_SHIFT_IN: begin
                if (s.vertical_shift != 6'd0) s.vertical_shift = s.vertical_shift - 6'd1;
                if (s.vertical_shift == 6'd0) begin
                  s.phase = PH_HOLD;
                  s.shift_from_top = top_in;
                end
              end
              PH_HOLD: begin
                if (s.phase_ticks != 8'hFF) s.phase_ticks = s.phase_ticks + 8'd1;
                if (int'(s.phase_ticks) > PAUSE_LIMIT) begin
                  s.phase = PH_SHIFT_OUT;
                  s.phase_ticks = '0;
                  if (zero_shift) s.vertical_shift = '0;
                end
              end
              PH_SHIFT_OUT: begin
                if (mode == MODE_TOP_SCROLL) begin
                  if (off > limit) req = 1'b1;
                end else begin
                  if (s.vertical_shift != 6'd63) s.vertical_shift = s.vertical_shift + 6'd1;
                  if (int'(s.vertical_shift) > SCREEN_ROWS) begin
                    s.phase = PH_ADVANCE;
                    s.shift_from_top = top_out;
                  end
                end
              end
              default: begin
                if (mode == MODE_TOP_SCROLL) begin
                  if (off > limit) req = 1'b1;
                end else begin
                  s.shift_from_top = top_out;
                  s.phase = PH_SHIFT_IN;
                  s.phase_ticks = '0;
                  s.vertical_shift = ROWS_SHIFT;
                  s.window_offset = sat_offset(off + SCREEN_BYTES);
                  if (16'(s.window_offset) > limit) req = 1'b1;
                end
              end
            endcase
            if (mode == MODE_TOP_SCROLL) s.window_offset = sat_offset(off + inc);
          end
          MODE_CONTINUOUS: begin
            s.window_offset = sat_offset(off + inc);
            if (16'(s.window_offset) > limit) req = 1'b1;
          end
          default: begin
            req = 1'b1;
          end
        endcase
        if (req) begin
          nf = {1'b0, s.current_frame} + 4'd1;
          if (int'(nf) >= FRAME_COUNT) nf = '0;
          s.current_frame = nf[2:0];
        end
      end
    end
    nxt = s;
    frame_request = req;
  end

endmodule

`default_nettype wire

### rtl/led_matrix_scroll_sequencer_core.sv
// Top level of the LED matrix scroll sequencer: config registers, state
// registers and a two-entry output buffer. Depends on lss_pkg and lss_step.
//
// Each accepted transaction (a millisecond tick or a frame start) updates the
// sequencer state in the same cycle it is taken and produces exactly one
// result, shown to the master after any earlier result. One transaction is
// accepted every cycle; the only limit is the two-entry output buffer, so
// s_tready drops only after two results are waiting on a stalled m_tready.
// Write the config registers only while no results are pending.
`default_nettype none

module led_matrix_scroll_sequencer_core #(
  parameter int SCREEN_COLUMNS = lss_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = lss_pkg::SCREEN_ROWS_DEF,
  parameter int HIDDEN_COLUMNS = lss_pkg::HIDDEN_COLUMNS_DEF,
  parameter int PAUSE_LIMIT    = lss_pkg::PAUSE_LIMIT_DEF,
  parameter int FAST_THRESHOLD = lss_pkg::FAST_THRESHOLD_DEF,
  parameter int FRAME_COUNT    = lss_pkg::FRAME_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lss_pkg::IN_DATA_W-1:0]       s_tdata,  // [2:0] start_frame
  input  logic [0:0]                          s_tuser,  // [0] operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [13:0] shown_offset, [19:14] shown_shift, [20] shift_toward_top,
  // [21] display_enabled, [22] frame_request, [25:23] requested_frame
  output logic [lss_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [lss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lss_pkg::*;

  cfg_t                  cfg;
  seq_state_t            state;
  seq_state_t            state_next;
  logic                  frame_request;
  logic [OUT_DATA_W-1:0] result;
  logic                  accept;
  logic                  take;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;

  lss_step #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS(SCREEN_ROWS),
    .HIDDEN_COLUMNS(HIDDEN_COLUMNS),
    .PAUSE_LIMIT(PAUSE_LIMIT),
    .FAST_THRESHOLD(FAST_THRESHOLD),
    .FRAME_COUNT(FRAME_COUNT)
  ) u_step (
    .cfg(cfg),
    .cur(state),
    .operation(s_tuser[0]),
    .start_frame(s_tdata[2:0]),
    .nxt(state_next),
    .frame_request(frame_request)
  );

  assign accept = s_tvalid && s_tready;
  assign take = out_valid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  assign result = {6'd0, state_next.current_frame, frame_request, !state_next.pausing,
                   state_next.shift_from_top, state_next.vertical_shift,
                   state_next.window_offset};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period <= 8'd20;
      cfg.scroll_mode <= 3'(MODE_LEFT);
      cfg.text_columns <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_PERIOD:  cfg.step_period <= cfg_data[7:0];
        REG_SCROLL_MODE:  cfg.scroll_mode <= cfg_data[2:0];
        REG_TEXT_COLUMNS: cfg.text_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.rate_counter <= '0;
      state.window_offset <= '0;
      state.vertical_shift <= '0;
      state.shift_from_top <= 1'b1;
      state.pausing <= 1'b0;
      state.pause_ticks <= '0;
      state.phase <= PH_SHIFT_IN;
      state.phase_ticks <= '0;
      state.current_frame <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (accept) out_data <= result;
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_data <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### tb/tb_led_matrix_scroll_sequencer_core.sv
// Self-checking testbench for led_matrix_scroll_sequencer_core: streams ticks and frame
// starts, mirrors the sequencer state to predict every result and checks each field.
// Depends on lss_pkg and the RTL core.
module tb_led_matrix_scroll_sequencer_core;
  import lss_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int WINDOW_MIN = -8192;
  localparam int WINDOW_MAX = 8191;
  localparam int SCREEN_BYTES = 4 * SCREEN_COLUMNS_DEF;
  localparam int RANDOM_ITEMS = 560;
  localparam int SATURATION_TICKS = 530;
  localparam int RIGHT_TICKS = 40;
  localparam int SLOW_TICKS = 130;
  localparam int DRAIN_PAUSE = 4;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [13:0] offset;
    logic [5:0]  shift;
    logic        toward_top;
    logic        enabled;
    logic        request;
    logic [2:0]  frame;
  } view_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // mirrored registers and sequencer state
  logic [7:0]  cfg_period;
  logic [2:0]  cfg_mode;
  logic [10:0] cfg_cols;
  int          rate_cnt;
  int          offset;
  int          vshift;
  int          pause_cnt;
  int          hold_cnt;
  bit          from_top;
  bit          pausing;
  phase_t      ph;
  logic [2:0]  frame_idx;

  view_t expected_views[$];
  int    error_count = 0;
  int    gap_pct = 0;
  int    stall_pct = 0;
  int    stall_left = 0;
  int    idle_cycles = 0;

  always #1 clk = ~clk;

  led_matrix_scroll_sequencer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int idle_len(int pct);
    if (int'($urandom_range(0, 99)) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  function automatic void reset_mirror();
    cfg_period = 8'd20;
    cfg_mode = MODE_LEFT;
    cfg_cols = '0;
    rate_cnt = 0;
    offset = 0;
    vshift = 0;
    from_top = 1'b1;
    pausing = 1'b0;
    pause_cnt = 0;
    ph = PH_SHIFT_IN;
    hold_cnt = 0;
    frame_idx = '0;
  endfunction

  function automatic mode_t active_mode();
    return (cfg_mode >= MODE_UNUSED) ? MODE_UNUSED : mode_t'(cfg_mode);
  endfunction

  function automatic int active_cols();
    return (cfg_cols > MAX_TEXT_COLUMNS) ? 0 : int'(cfg_cols);
  endfunction

  function automatic void move_window(int v);
    offset = (v < WINDOW_MIN) ? WINDOW_MIN : ((v > WINDOW_MAX) ? WINDOW_MAX : v);
  endfunction

  function automatic bit advance_frame();
    frame_idx = 3'((int'(frame_idx) + 1) % FRAME_COUNT_DEF);
    return 1'b1;
  endfunction

  function automatic void count_pause();
    int old;
    old = pause_cnt;
    if (pause_cnt < 255) pause_cnt++;
    if (old > PAUSE_LIMIT_DEF) begin
      pausing = 1'b0;
      pause_cnt = 0;
    end
  endfunction

  // shift-in and hold phases; returns 1 when one of them handled the step
  function automatic bit shift_in_or_hold(bit top_in, bit clear_shift);
    if (ph == PH_SHIFT_IN) begin
      if (vshift > 0) vshift--;
      if (vshift == 0) begin
        ph = PH_HOLD;
        from_top = top_in;
      end
      return 1'b1;
    end
    if (ph == PH_HOLD) begin
      if (hold_cnt < 255) hold_cnt++;
      if (hold_cnt > PAUSE_LIMIT_DEF) begin
        ph = PH_SHIFT_OUT;
        hold_cnt = 0;
        if (clear_shift) vshift = 0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit vertical_step(bit top_in, bit clear_shift, bit top_out, int limit);
    if (shift_in_or_hold(top_in, clear_shift)) return 1'b0;
    if (ph == PH_SHIFT_OUT) begin
      if (vshift < 63) vshift++;
      if (vshift > SCREEN_ROWS_DEF) begin
        ph = PH_ADVANCE;
        from_top = top_out;
      end
      return 1'b0;
    end
    from_top = top_out;
    ph = PH_SHIFT_IN;
    hold_cnt = 0;
    vshift = SCREEN_ROWS_DEF & 63;
    move_window(offset + SCREEN_BYTES);
    return (offset > limit) ? advance_frame() : 1'b0;
  endfunction

  function automatic bit run_step();
    int stride;
    int limit;
    bit req;
    stride = (cfg_period > FAST_THRESHOLD_DEF) ? 4 : 8;
    limit = 4 * (active_cols() + SCREEN_COLUMNS_DEF + HIDDEN_COLUMNS_DEF);
    req = 1'b0;
    case (active_mode())
      MODE_LEFT: begin
        if (!pausing) move_window(offset + stride);
        if (offset == SCREEN_BYTES) pausing = 1'b1;
        if (pausing) count_pause();
        if (offset > limit) req = advance_frame();
      end
      MODE_RIGHT: begin
        if (!pausing) move_window(offset - stride);
        if (offset == SCREEN_BYTES) pausing = 1'b1;
        if (pausing) begin
          count_pause();
        end else if (offset < 0) begin
          hold_cnt = 0;
          req = advance_frame();
        end
      end
      MODE_UP: req = vertical_step(1'b1, 1'b0, 1'b0, limit);
      MODE_DOWN: req = vertical_step(1'b0, 1'b1, 1'b1, limit);
      MODE_CONTINUOUS: begin
        move_window(offset + stride);
        if (offset > limit) req = advance_frame();
      end
      MODE_TOP_SCROLL: begin
        if (!shift_in_or_hold(1'b0, 1'b1)) begin
          if (offset > limit) req = advance_frame();
        end
        move_window(offset + stride);
      end
      default: req = advance_frame();
    endcase
    return req;
  endfunction

  function automatic void start_frame(logic [2:0] idx);
    mode_t m;
    m = active_mode();
    frame_idx = (idx >= FRAME_COUNT_DEF) ? 3'd0 : idx;
    if (m == MODE_UNUSED) return;
    hold_cnt = 0;
    pausing = 1'b0;
    ph = PH_SHIFT_IN;
    vshift = 0;
    case (m)
      MODE_RIGHT: move_window(4 * active_cols());
      MODE_UP, MODE_DOWN: begin
        from_top = (m == MODE_DOWN);
        vshift = SCREEN_ROWS_DEF & 63;
        move_window(SCREEN_BYTES);
      end
      MODE_TOP_SCROLL: begin
        from_top = 1'b1;
        vshift = SCREEN_ROWS_DEF & 63;
        move_window(0);
      end
      default: move_window(0);
    endcase
  endfunction

  function automatic void predict_view(op_t op, logic [2:0] idx);
    view_t v;
    bit req;
    req = 1'b0;
    if (op == OP_START) begin
      start_frame(idx);
    end else begin
      if (rate_cnt < 16'hFFFF) rate_cnt++;
      if (rate_cnt > cfg_period) begin
        req = run_step();
        rate_cnt = 0;
      end
    end
    v.offset = 14'(offset);
    v.shift = 6'(vshift);
    v.toward_top = from_top;
    v.enabled = !pausing;
    v.request = req;
    v.frame = frame_idx;
    expected_views.push_back(v);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_views
    view_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        check_field("shown_offset", $signed(want.offset), $signed(m_tdata[13:0]));
        check_field("shown_shift", want.shift, m_tdata[19:14]);
        check_field("shift_toward_top", want.toward_top, m_tdata[20]);
        check_field("display_enabled", want.enabled, m_tdata[21]);
        check_field("frame_request", want.request, m_tdata[22]);
        check_field("requested_frame", want.frame, m_tdata[25:23]);
        check_field("padding", 0, m_tdata[OUT_DATA_W-1:26]);
      end
    end
  end

  always @(posedge clk) begin : sink_pacing
    int n;
    n = idle_len(stall_pct);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (n > 0) begin
      m_tready <= 1'b0;
      stall_left <= n - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_PERIOD: cfg_period = value[7:0];
      REG_SCROLL_MODE: cfg_mode = value[2:0];
      REG_TEXT_COLUMNS: cfg_cols = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays high across back-to-back transactions
  task automatic send_transaction(input op_t op, input logic [2:0] idx);
    int gap;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= IN_DATA_W'(idx);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_view(op, idx);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic test_register_corners();
    gap_pct = 0;
    stall_pct = 0;
    write_reg(REG_STEP_PERIOD, 11'd0);
    write_reg(REG_SCROLL_MODE, 11'h7FF);
    write_reg(REG_TEXT_COLUMNS, 11'd1025);
    write_reg(REG_SPARE, 11'h7FF);
    send_transaction(OP_START, 3'd7);
    send_transaction(OP_TICK, 3'd7);
    send_transaction(OP_TICK, 3'd0);
    wait_drained();
    write_reg(REG_SCROLL_MODE, 11'(MODE_LEFT));
    send_transaction(OP_START, 3'd0);
    send_transaction(OP_TICK, 3'd5);
    wait_drained();
  endtask

  task automatic test_every_mode();
    gap_pct = 30;
    stall_pct = 30;
    write_reg(REG_TEXT_COLUMNS, 11'd1024);
    for (int m = 0; m <= int'(MODE_UNUSED); m++) begin
      write_reg(REG_SCROLL_MODE, 11'(m));
      send_transaction(OP_START, 3'(m));
      send_transaction(OP_TICK, 3'(~m));
      wait_drained();
    end
  endtask

  // a right-mode start parks the window at the text end, continuous mode then
  // runs it into the upper clamp; a short right run crosses below zero
  task automatic test_offset_saturation();
    gap_pct = 5;
    stall_pct = 5;
    write_reg(REG_STEP_PERIOD, 11'd0);
    write_reg(REG_TEXT_COLUMNS, 11'd1024);
    write_reg(REG_SCROLL_MODE, 11'(MODE_RIGHT));
    send_transaction(OP_START, 3'd2);
    wait_drained();
    write_reg(REG_SCROLL_MODE, 11'(MODE_CONTINUOUS));
    repeat (SATURATION_TICKS) send_transaction(OP_TICK, 3'($urandom));
    wait_drained();
    write_reg(REG_SCROLL_MODE, 11'(MODE_RIGHT));
    write_reg(REG_TEXT_COLUMNS, 11'd0);
    send_transaction(OP_START, 3'd6);
    repeat (RIGHT_TICKS) send_transaction(OP_TICK, 3'($urandom));
    wait_drained();
  endtask

  // a start mid-run must not clear the rate counter
  task automatic test_slow_rate();
    gap_pct = 40;
    stall_pct = 40;
    write_reg(REG_STEP_PERIOD, 11'd255);
    write_reg(REG_SCROLL_MODE, 11'(MODE_LEFT));
    send_transaction(OP_START, 3'd4);
    repeat (SLOW_TICKS) send_transaction(OP_TICK, 3'($urandom));
    send_transaction(OP_START, 3'd1);
    repeat (SLOW_TICKS) send_transaction(OP_TICK, 3'($urandom));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int sent;
    int run_len;
    int r;
    logic [7:0] period;
    logic [10:0] cols;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gap_pct = 20 * int'($urandom_range(0, 2));
      stall_pct = 20 * int'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 40) period = 8'($urandom_range(0, 2));
      else if (r < 70) period = 8'($urandom_range(3, 8));
      else if (r < 80) period = 8'd255;
      else period = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 25) cols = 11'($urandom_range(0, 8));
      else if (r < 50) cols = 11'($urandom_range(9, 64));
      else if (r < 60) cols = 11'd1024;
      else if (r < 70) cols = 11'($urandom_range(1025, 2047));
      else cols = 11'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) < 7) write_reg(REG_STEP_PERIOD, {3'($urandom), period});
      write_reg(REG_SCROLL_MODE, {8'($urandom), 3'($urandom_range(0, 7))});
      if ($urandom_range(0, 9) < 7) write_reg(REG_TEXT_COLUMNS, cols);
      run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(20, 160) : $urandom_range(160, 400);
      if ($urandom_range(0, 9) != 0) begin
        send_transaction(OP_START, 3'($urandom));
        sent++;
      end
      repeat (run_len) begin
        if ($urandom_range(0, 99) < 4) send_transaction(OP_START, 3'($urandom));
        else send_transaction(OP_TICK, 3'($urandom));
        sent++;
      end
      wait_drained();
    end
  endtask

  initial begin
    reset_mirror();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_register_corners();
    test_every_mode();
    test_offset_saturation();
    test_slow_rate();
    test_random_phases();
    wait_drained();
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/lss_pkg.sv
rtl/lss_step.sv
rtl/led_matrix_scroll_sequencer_core.sv
tb/tb_led_matrix_scroll_sequencer_core.sv
